// ===== design/fdfc_pkg.sv =====
// Shared types, codes and constants for the floppy DMA FIFO controller.
// No dependencies; every other file in the design imports this package.
package fdfc_pkg;

  // Default sizing handed to the top level
  localparam int FIFO_DEPTH_DEFAULT        = 6;
  localparam int BYTE_VALID_WINDOW_DEFAULT = 7;

  // Operation codes of an incoming transaction
  localparam logic [1:0] OP_LENGTH_WRITE = 2'd0;
  localparam logic [1:0] OP_DISK_BYTE    = 2'd1;
  localparam logic [1:0] OP_DMA_SLOT     = 2'd2;
  localparam logic [1:0] OP_STATUS_READ  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_NONE       = 2'd0;
  localparam logic [1:0] KIND_MEM_WORD   = 2'd1;
  localparam logic [1:0] KIND_DRIVE_BYTE = 2'd2;
  localparam logic [1:0] KIND_STATUS     = 2'd3;

  // DMA modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_WRITE = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SYNC_WORD   = 1'b0;
  localparam logic CFG_SYNC_ENABLE = 1'b1;

  // Length register fields and the sync mark reset value
  localparam int          LEN_DMA_EN_BIT  = 15;
  localparam int          LEN_WRITE_BIT   = 14;
  localparam logic [15:0] LEN_COUNT_MASK  = 16'h3FFF;
  localparam logic [15:0] SYNC_WORD_RESET = 16'h4489;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] value;
    logic [7:0]  disk_byte;
    logic        drive_selected;
    logic        dma_master_enable;
    logic [31:0] now_cycle;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic        sync_irq;
    logic        block_irq;
    logic [1:0]  dma_mode;
    logic        last;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic pop;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic flush_req;
    logic flush_last;
  } ctrl_stat_t;

endpackage

// ===== design/fdfc_ctrl.sv =====
// Sequencer for the floppy DMA FIFO controller: handshakes and item steps.
// Depends on fdfc_pkg; drives the datapath through ctrl_cmd_t.
module fdfc_ctrl
  import fdfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_free;
  logic       rsp_load;

  // The output register can take a result when empty or being drained
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  // Step through capture, execute and flush
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.pop     = 1'b0;
    rsp_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (rsp_free) begin
          cmd.exec = 1'b1;
          if (stat.flush_req) begin
            state_next = ST_FLUSH;
          end else begin
            rsp_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (rsp_free) begin
          cmd.pop  = 1'b1;
          rsp_load = 1'b1;
          if (stat.flush_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/fdfc_datapath.sv =====
// Datapath of the floppy DMA FIFO controller: mode, length, byte FIFO,
// sync compare, status word and the result register. Depends on fdfc_pkg.
module fdfc_datapath
  import fdfc_pkg::*;
#(
  parameter int FIFO_DEPTH        = FIFO_DEPTH_DEFAULT,
  parameter int BYTE_VALID_WINDOW = BYTE_VALID_WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  output rsp_t        rsp
);

  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam int IW = $clog2(FIFO_DEPTH);
  localparam logic [FW-1:0] FILL_FULL  = FW'(FIFO_DEPTH);
  localparam logic [FW-1:0] FILL_TRIM  = FW'(FIFO_DEPTH - 2);
  localparam logic [FW:0]   FILL_LIMIT = (FW + 1)'(FIFO_DEPTH);
  localparam logic [31:0]   WINDOW     = 32'(BYTE_VALID_WINDOW);

  // Configuration
  logic [15:0] sync_word;
  logic        word_sync_enable;

  // Captured transaction
  req_t item;

  // Controller state
  logic [1:0]                  mode;
  logic [15:0]                 length_reg;
  logic [FIFO_DEPTH-1:0][7:0]  fifo_bytes;
  logic [FW-1:0]               fifo_fill;
  logic [7:0]                  last_disk_byte;
  logic [31:0]                 last_byte_time;
  logic                        word_equal;

  logic [1:0]                  mode_next;
  logic [15:0]                 length_reg_next;
  logic [FIFO_DEPTH-1:0][7:0]  fifo_bytes_next;
  logic [FW-1:0]               fifo_fill_next;
  logic [7:0]                  last_disk_byte_next;
  logic [31:0]                 last_byte_time_next;
  logic                        word_equal_next;

  // Helpers
  logic [FW-1:0]               fill_base;
  logic [FW-1:0]               push_fill;
  logic [FIFO_DEPTH-1:0][7:0]  push_bytes;
  logic [FW-1:0]               fill_m1;
  logic [FW-1:0]               fill_m2;
  logic [IW-1:0]               pop_idx;
  logic [IW-1:0]               pop2_idx;
  logic                        room2;
  logic [15:0]                 count_dec;
  logic [31:0]                 elapsed;
  logic                        sync_hit;
  logic                        flush_req;
  rsp_t                        exec_rsp;
  rsp_t                        flush_rsp;
  logic                        rsp_load;

  // Single-byte push: a full FIFO drops its oldest word first
  assign fill_base  = (fifo_fill >= FILL_FULL) ? FILL_TRIM : fifo_fill;
  assign push_fill  = fill_base + FW'(1);
  assign push_bytes = {fifo_bytes[FIFO_DEPTH-2:0], item.disk_byte};
  assign sync_hit   = (push_fill >= FW'(2)) &&
                      ({push_bytes[1], push_bytes[0]} == sync_word);

  // Pop positions: the oldest byte sits at fill - 1
  assign fill_m1   = fifo_fill - FW'(1);
  assign fill_m2   = fifo_fill - FW'(2);
  assign pop_idx   = fill_m1[IW-1:0];
  assign pop2_idx  = fill_m2[IW-1:0];
  assign room2     = ({1'b0, fifo_fill} + (FW + 1)'(2)) <= FILL_LIMIT;
  assign count_dec = length_reg - 16'd1;
  assign elapsed   = item.now_cycle - last_byte_time;

  // Execute one transaction
  always_comb begin
    mode_next           = mode;
    length_reg_next     = length_reg;
    fifo_bytes_next     = fifo_bytes;
    fifo_fill_next      = fifo_fill;
    last_disk_byte_next = last_disk_byte;
    last_byte_time_next = last_byte_time;
    word_equal_next     = word_equal;
    flush_req           = 1'b0;
    exec_rsp            = '0;
    exec_rsp.kind       = KIND_NONE;
    case (item.operation)
      OP_LENGTH_WRITE: begin
        length_reg_next = item.value;
        if (!item.value[LEN_DMA_EN_BIT]) begin
          mode_next       = MODE_OFF;
          fifo_bytes_next = '0;
          fifo_fill_next  = '0;
        end else if (length_reg[LEN_DMA_EN_BIT]) begin
          if (length_reg[LEN_WRITE_BIT] && item.value[LEN_WRITE_BIT]) begin
            mode_next = MODE_WRITE;
          end else begin
            mode_next = word_sync_enable ? MODE_WAIT : MODE_READ;
          end
          fifo_bytes_next = '0;
          fifo_fill_next  = '0;
        end
      end
      OP_DISK_BYTE: begin
        if (item.drive_selected && (mode == MODE_WAIT || mode == MODE_READ)) begin
          last_disk_byte_next = item.disk_byte;
          last_byte_time_next = item.now_cycle;
          fifo_bytes_next     = push_bytes;
          fifo_fill_next      = push_fill;
          word_equal_next     = sync_hit;
          if (sync_hit) begin
            exec_rsp.sync_irq = 1'b1;
            if (mode == MODE_WAIT) begin
              mode_next       = MODE_READ;
              fifo_bytes_next = '0;
              fifo_fill_next  = '0;
            end
          end
        end else if (item.drive_selected && mode == MODE_WRITE &&
                     fifo_fill != '0) begin
          exec_rsp.kind  = KIND_DRIVE_BYTE;
          exec_rsp.data  = {8'h00, fifo_bytes[pop_idx]};
          fifo_fill_next = fill_m1;
        end
      end
      OP_DMA_SLOT: begin
        if (item.drive_selected && (length_reg & LEN_COUNT_MASK) != '0) begin
          if (mode == MODE_READ && fifo_fill >= FW'(2)) begin
            exec_rsp.kind   = KIND_MEM_WORD;
            exec_rsp.data   = {fifo_bytes[pop_idx], fifo_bytes[pop2_idx]};
            fifo_fill_next  = fill_m2;
            length_reg_next = count_dec;
            if ((count_dec & LEN_COUNT_MASK) == '0) begin
              exec_rsp.block_irq = 1'b1;
              mode_next          = MODE_OFF;
            end
          end else if (mode == MODE_WRITE && room2) begin
            fifo_bytes_next = {fifo_bytes[FIFO_DEPTH-3:0], item.value};
            fifo_fill_next  = fifo_fill + FW'(2);
            length_reg_next = count_dec;
            if ((count_dec & LEN_COUNT_MASK) == '0) begin
              // Final word: drain the whole FIFO to the drive afterwards
              flush_req = 1'b1;
              mode_next = MODE_OFF;
            end
          end
        end
      end
      OP_STATUS_READ: begin
        exec_rsp.kind        = KIND_STATUS;
        exec_rsp.data[15]    = (elapsed <= WINDOW);
        exec_rsp.data[14]    = item.dma_master_enable && (mode != MODE_OFF);
        exec_rsp.data[13]    = length_reg[LEN_WRITE_BIT];
        exec_rsp.data[12]    = word_equal;
        exec_rsp.data[7:0]   = last_disk_byte;
      end
      default: begin
        exec_rsp.kind = KIND_NONE;
      end
    endcase
    exec_rsp.dma_mode = mode_next;
    exec_rsp.last     = 1'b1;
  end

  // One flushed byte per result, oldest first
  always_comb begin
    flush_rsp           = '0;
    flush_rsp.kind      = KIND_DRIVE_BYTE;
    flush_rsp.data      = {8'h00, fifo_bytes[pop_idx]};
    flush_rsp.block_irq = 1'b1;
    flush_rsp.dma_mode  = mode;
    flush_rsp.last      = (fifo_fill == FW'(1));
  end

  assign stat.flush_req  = flush_req;
  assign stat.flush_last = (fifo_fill == FW'(1));
  assign rsp_load        = (cmd.exec && !flush_req) || cmd.pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word        <= SYNC_WORD_RESET;
      word_sync_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_WORD:   sync_word        <= cfg_data;
        CFG_SYNC_ENABLE: word_sync_enable <= cfg_data[0];
        default:         sync_word        <= sync_word;
      endcase
    end
  end

  // Controller state: advance on execute, drain on flush pop
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_OFF;
      length_reg     <= '0;
      fifo_bytes     <= '0;
      fifo_fill      <= '0;
      last_disk_byte <= '0;
      last_byte_time <= '0;
      word_equal     <= 1'b0;
    end else if (cmd.exec) begin
      mode           <= mode_next;
      length_reg     <= length_reg_next;
      fifo_bytes     <= fifo_bytes_next;
      fifo_fill      <= fifo_fill_next;
      last_disk_byte <= last_disk_byte_next;
      last_byte_time <= last_byte_time_next;
      word_equal     <= word_equal_next;
    end else if (cmd.pop) begin
      fifo_fill <= fill_m1;
    end
  end

  // Transaction capture and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
    if (rsp_load) begin
      rsp <= cmd.pop ? flush_rsp : exec_rsp;
    end
  end

endmodule

// ===== design/floppy_dma_fifo_controller.sv =====
// Top level of the floppy DMA FIFO controller: sequencer plus datapath.
// Depends on fdfc_pkg, fdfc_ctrl and fdfc_datapath.
//
// Disk DMA controller with a byte FIFO and sync-mark detection. Each request
// transaction is a length write, a disk byte event, a DMA word slot or a
// status read, and yields one or more response transactions, the final one
// flagged by last. Each request is first captured and then executed in the
// datapath, which loads the output register once the response side has
// room; the next request is taken in the cycle after that. The final word
// of a write transfer instead drains the FIFO, up to FIFO_DEPTH bytes, one
// byte per cycle while the response side does not stall. The single output
// register is the limit: it holds one response at a time. Configuration
// writes are taken at any time but belong in idle periods.
module floppy_dma_fifo_controller
  import fdfc_pkg::*;
#(
  parameter int FIFO_DEPTH        = FIFO_DEPTH_DEFAULT,
  parameter int BYTE_VALID_WINDOW = BYTE_VALID_WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequence the transaction
  fdfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold state and compute results
  fdfc_datapath #(
    .FIFO_DEPTH        (FIFO_DEPTH),
    .BYTE_VALID_WINDOW (BYTE_VALID_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule
